// ===== sv/kmdm_pkg.sv =====
package kmdm_pkg;

   localparam int LABEL_W   = 12;
   localparam int COORD_W   = 6;
   localparam int DIM_W     = 7;
   localparam int CSR_IDX_W = 1;
   localparam int PROD_W    = COORD_W + DIM_W;
   localparam int LIN_W     = PROD_W + 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_GRID_COLUMNS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_ROWS    = 1'd1;

   localparam logic [DIM_W-1:0] GRID_COLUMNS_RST = 7'd64;
   localparam logic [DIM_W-1:0] GRID_ROWS_RST    = 7'd64;

   // request commands
   localparam logic CMD_DOOR    = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   typedef struct packed {
      logic load_fields;
      logic calc_mul;
      logic calc_idx;
      logic rd_a;
      logic rd_b;
      logic lat_a;
      logic lat_b;
      logic clr_wr;
      logic scan_rd;
   } ctrl_cmd_type;

   typedef struct packed {
      logic bad;
      logic labels_equal;
      logic cnt_last;
   } dp_status_type;

endpackage

// ===== sv/kmdm_if.sv =====
interface kmdm_req_if import kmdm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               cmd;
   logic [COORD_W-1:0] first_row;
   logic [COORD_W-1:0] first_col;
   logic [COORD_W-1:0] second_row;
   logic [COORD_W-1:0] second_col;

   modport source (output valid, cmd, first_row, first_col, second_row, second_col,
                   input ready);
   modport sink   (input valid, cmd, first_row, first_col, second_row, second_col,
                   output ready);
endinterface

interface kmdm_rsp_if;
   logic valid;
   logic ready;
   logic door_open;
   logic bad_coord;

   modport source (output valid, door_open, bad_coord, input ready);
   modport sink   (input valid, door_open, bad_coord, output ready);
endinterface

interface kmdm_csr_if import kmdm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DIM_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/kruskal_maze_door_merge_core.sv =====
// channel   dir  handshake      payload
// req_ch    in   valid/ready    cmd, first_row, first_col, second_row, second_col
// rsp_ch    out  valid/ready    door_open, bad_coord
// csr_ch    in   valid/ready    index (0 grid_columns, 1 grid_rows), data
//
// one request at a time; a bad coordinate is reported once the index calculation flags it,
// a door between cells of one set once both labels are read, a merge after a scan of the
// whole label store and a restart after a clearing pass, the label store handling one
// entry a cycle; after reset a clearing pass writes every label to its index
// with req_ch.ready low; csr writes are taken throughout
// a finished result waits in the output register while the next request is taken
module kruskal_maze_door_merge_core import kmdm_pkg::*; #(
   parameter int MAX_CELLS = 4096
) (
   input logic       clock,
   input logic       reset,
   kmdm_req_if.sink  req_ch,
   kmdm_rsp_if.source rsp_ch,
   kmdm_csr_if.sink  csr_ch
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // register writes always land, the block is idle by contract
   assign csr_ch.ready = 1'b1;

   // sequencer: clearing pass, index calculation, label reads and table scan
   kmdm_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_cmd       (req_ch.cmd),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_door_open (rsp_ch.door_open),
      .rsp_bad_coord (rsp_ch.bad_coord),
      .cmd           (cmd),
      .status        (status)
   );

   // grid registers, linear index arithmetic and the label store
   kmdm_dpath #(
      .MAX_CELLS (MAX_CELLS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .first_row  (req_ch.first_row),
      .first_col  (req_ch.first_col),
      .second_row (req_ch.second_row),
      .second_col (req_ch.second_col),
      .csr_wr     (csr_ch.valid),
      .csr_index  (csr_ch.index),
      .csr_data   (csr_ch.data)
   );

endmodule

// ===== sv/kmdm_ram.sv =====
module kmdm_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/kmdm_dpath.sv =====
module kmdm_dpath import kmdm_pkg::*; #(
   parameter int MAX_CELLS = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_cmd_type         cmd,
   output dp_status_type        status,
   input  logic [COORD_W-1:0]   first_row,
   input  logic [COORD_W-1:0]   first_col,
   input  logic [COORD_W-1:0]   second_row,
   input  logic [COORD_W-1:0]   second_col,
   input  logic                 csr_wr,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_data
);

   localparam int IDX_W = $clog2(MAX_CELLS);
   localparam int CMP_W = 17;

   logic [DIM_W-1:0]   cols_ff, cols_in, rows_ff, rows_in;
   logic [COORD_W-1:0] fr_ff, fc_ff, sr_ff, sc_ff;
   logic [PROD_W-1:0]  prod_a_ff, prod_b_ff;
   logic               coord_bad_ff, coord_bad_in;
   logic [LIN_W-1:0]   lin_a_ff, lin_b_ff, lin_a_in, lin_b_in;
   logic               bad_ff, bad_in;
   logic [LABEL_W-1:0] la_ff, lb_ff;
   logic [IDX_W-1:0]   cnt_ff, cnt_in;
   logic               pend_ff;
   logic [IDX_W-1:0]   pend_addr_ff;
   logic               cnt_last;

   logic               ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]   ram_wr_addr, ram_rd_addr;
   logic [LABEL_W-1:0] ram_wr_data, ram_rd_data;

   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_wr) begin
         case (csr_index)
            REG_GRID_COLUMNS: cols_in = csr_data;
            REG_GRID_ROWS:    rows_in = csr_data;
            default: ;
         endcase
      end
   end

   assign coord_bad_in = ({1'b0, fr_ff} >= rows_ff) || ({1'b0, sr_ff} >= rows_ff) ||
                         ({1'b0, fc_ff} >= cols_ff) || ({1'b0, sc_ff} >= cols_ff);

   assign lin_a_in = LIN_W'(fc_ff) + LIN_W'(prod_a_ff);
   assign lin_b_in = LIN_W'(sc_ff) + LIN_W'(prod_b_ff);
   assign bad_in   = coord_bad_ff ||
                     (CMP_W'(lin_a_in) >= CMP_W'(MAX_CELLS)) ||
                     (CMP_W'(lin_b_in) >= CMP_W'(MAX_CELLS));

   assign cnt_last = (cnt_ff == IDX_W'(MAX_CELLS - 1));
   assign cnt_in   = cnt_last ? '0 : cnt_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= GRID_COLUMNS_RST;
         rows_ff <= GRID_ROWS_RST;
         cnt_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         cols_ff <= cols_in;
         rows_ff <= rows_in;
         if (cmd.clr_wr || cmd.scan_rd) begin
            cnt_ff <= cnt_in;
         end
         pend_ff <= cmd.scan_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_fields) begin
         fr_ff <= first_row;
         fc_ff <= first_col;
         sr_ff <= second_row;
         sc_ff <= second_col;
      end
      if (cmd.calc_mul) begin
         prod_a_ff    <= PROD_W'(fr_ff) * PROD_W'(cols_ff);
         prod_b_ff    <= PROD_W'(sr_ff) * PROD_W'(cols_ff);
         coord_bad_ff <= coord_bad_in;
      end
      if (cmd.calc_idx) begin
         lin_a_ff <= lin_a_in;
         lin_b_ff <= lin_b_in;
         bad_ff   <= bad_in;
      end
      if (cmd.lat_a) begin
         la_ff <= ram_rd_data;
      end
      if (cmd.lat_b) begin
         lb_ff <= ram_rd_data;
      end
      pend_addr_ff <= cnt_ff;
   end

   // scan: read one entry a cycle, rewrite it in the following cycle if it holds the first label
   always_comb begin
      ram_rd_en   = cmd.rd_a || cmd.rd_b || cmd.scan_rd;
      ram_rd_addr = cnt_ff;
      if (cmd.rd_a) begin
         ram_rd_addr = IDX_W'(lin_a_ff);
      end else if (cmd.rd_b) begin
         ram_rd_addr = IDX_W'(lin_b_ff);
      end
      ram_wr_en   = cmd.clr_wr || (pend_ff && (ram_rd_data == la_ff));
      ram_wr_addr = cmd.clr_wr ? cnt_ff : pend_addr_ff;
      ram_wr_data = cmd.clr_wr ? LABEL_W'(cnt_ff) : lb_ff;
   end

   kmdm_ram #(
      .WIDTH (LABEL_W),
      .DEPTH (MAX_CELLS)
   ) u_label_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign status.bad          = bad_ff;
   assign status.labels_equal = (ram_rd_data == la_ff);
   assign status.cnt_last     = cnt_last;

endmodule

// ===== sv/kmdm_ctrl.sv =====
module kmdm_ctrl import kmdm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_cmd,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_door_open,
   output logic          rsp_bad_coord,
   output ctrl_cmd_type  cmd,
   input  dp_status_type status
);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_MUL   = 4'd2;
   localparam logic [3:0] S_ADDR  = 4'd3;
   localparam logic [3:0] S_RDA   = 4'd4;
   localparam logic [3:0] S_RDB   = 4'd5;
   localparam logic [3:0] S_CMP   = 4'd6;
   localparam logic [3:0] S_SCAN  = 4'd7;
   localparam logic [3:0] S_DRAIN = 4'd8;
   localparam logic [3:0] S_DONE  = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       restart_ff, restart_in;
   logic       open_ff, open_in;
   logic       bad_ff, bad_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_open_ff, rsp_bad_ff;
   logic       load_rsp;

   always_comb begin
      state_in   = state_ff;
      restart_in = restart_ff;
      open_in    = open_ff;
      bad_in     = bad_ff;
      load_rsp   = 1'b0;
      cmd        = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (status.cnt_last) begin
               state_in = restart_ff ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_fields = 1'b1;
               restart_in      = (req_cmd == CMD_RESTART);
               open_in         = 1'b0;
               bad_in          = 1'b0;
               state_in        = (req_cmd == CMD_RESTART) ? S_CLEAR : S_MUL;
            end
         end
         S_MUL: begin
            cmd.calc_mul = 1'b1;
            state_in     = S_ADDR;
         end
         S_ADDR: begin
            cmd.calc_idx = 1'b1;
            state_in     = S_RDA;
         end
         S_RDA: begin
            if (status.bad) begin
               bad_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.rd_a = 1'b1;
               state_in = S_RDB;
            end
         end
         S_RDB: begin
            cmd.lat_a = 1'b1;
            cmd.rd_b  = 1'b1;
            state_in  = S_CMP;
         end
         S_CMP: begin
            cmd.lat_b = 1'b1;
            state_in  = status.labels_equal ? S_DONE : S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (status.cnt_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            open_in  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         restart_ff   <= 1'b0;
         open_ff      <= 1'b0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         restart_ff   <= restart_in;
         open_ff      <= open_in;
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_open_ff <= open_ff;
         rsp_bad_ff  <= bad_ff;
      end
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_door_open = rsp_open_ff;
   assign rsp_bad_coord = rsp_bad_ff;

endmodule

// ===== sv/kmdm_chk.sv =====
module kmdm_chk (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_door_open,
   input logic rsp_bad_coord
);

   // a pending result holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_door_open) &&
                                  $stable(rsp_bad_coord))
      else $error("result changed before its transfer");

   a_rsp_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_rsp_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_door_open && rsp_bad_coord))
      else $error("door opened on a bad coordinate");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in work");

endmodule

bind kruskal_maze_door_merge_core kmdm_chk u_kmdm_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_door_open (rsp_ch.door_open),
   .rsp_bad_coord (rsp_ch.bad_coord)
);
